[design/tmcr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmcr_pkg
// Shared types and constants for the tile map collision and reflect block.
// ----------------------------------------------------------------------------
package tmcr_pkg;

	localparam int POS_W  = 16;
	localparam int SIZE_W = 15;
	localparam int CELL_W = 6;
	localparam int CFG_W  = 7;
	localparam int CFG_IDX_W = 1;

	typedef enum logic [1:0] {
		OP_WRITE   = 2'd0,
		OP_CHECK   = 2'd1,
		OP_REFLECT = 2'd2
	} op_t;

	localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAP_HEIGHT = 1'b1;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic clear;
		logic load;
		logic write;
		logic test_z;
		logic center;
		logic edge_calc;
		logic cell_calc;
		logic bound;
		logic scan;
		logic commit;
		logic finish;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic       clear_last;
		logic [1:0] op;
		logic       win_oob;
		logic       scan_last;
		logic       out_busy;
	} status_t;

endpackage

[design/tmcr_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmcr_ctrl
// Sequencer: grid clearing after reset, item dispatch, the window tests of a
// check or reflect item and hand-off of the result to the output register.
// ----------------------------------------------------------------------------
module tmcr_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  tmcr_pkg::status_t status,
	output tmcr_pkg::cmd_t    cmd
);
	import tmcr_pkg::*;

	typedef enum logic [9:0] {
		S_CLEAR    = 10'b00_0000_0001,
		S_IDLE     = 10'b00_0000_0010,
		S_DISPATCH = 10'b00_0000_0100,
		S_CENTER   = 10'b00_0000_1000,
		S_EDGE     = 10'b00_0001_0000,
		S_CELL     = 10'b00_0010_0000,
		S_BOUND    = 10'b00_0100_0000,
		S_SCAN     = 10'b00_1000_0000,
		S_COMMIT   = 10'b01_0000_0000,
		S_FINISH   = 10'b10_0000_0000
	} state_t;

	state_t state_q, state_d;
	logic   test_z_q, test_z_d;

	always_comb begin
		state_d  = state_q;
		test_z_d = test_z_q;
		cmd      = '0;
		cmd.test_z = test_z_q;
		in_ready = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clear = 1'b1;
				if (status.clear_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				test_z_d = 1'b0;
				unique case (status.op) inside
					OP_WRITE: begin
						cmd.write = 1'b1;
						state_d   = S_FINISH;
					end
					OP_CHECK, OP_REFLECT: state_d = S_CENTER;
					default:              state_d = S_FINISH;
				endcase
			end
			S_CENTER: begin
				cmd.center = 1'b1;
				state_d    = S_EDGE;
			end
			S_EDGE: begin
				cmd.edge_calc = 1'b1;
				state_d       = S_CELL;
			end
			S_CELL: begin
				cmd.cell_calc = 1'b1;
				state_d       = S_BOUND;
			end
			S_BOUND: begin
				cmd.bound = 1'b1;
				state_d   = status.win_oob ? S_COMMIT : S_SCAN;
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (status.scan_last) state_d = S_COMMIT;
			end
			S_COMMIT: begin
				cmd.commit = 1'b1;
				// A reflect item runs the z-displaced test after the x one.
				if (status.op == OP_REFLECT && !test_z_q) begin
					test_z_d = 1'b1;
					state_d  = S_CENTER;
				end else begin
					state_d = S_FINISH;
				end
			end
			S_FINISH: begin
				if (!status.out_busy) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLEAR;
			test_z_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			test_z_q <= test_z_d;
		end
	end

endmodule

[design/tmcr_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmcr_dp
// Datapath: map size registers, occupancy memory, window edge arithmetic,
// cell scan counters, hit accumulation and the output register.
// ----------------------------------------------------------------------------
module tmcr_dp #(
	parameter int MAX_COLS = 64,
	parameter int MAX_ROWS = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  tmcr_pkg::cmd_t                      cmd,
	output tmcr_pkg::status_t                   status,
	input  logic                                cfg_valid,
	input  logic [tmcr_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [tmcr_pkg::CFG_W-1:0]          cfg_data,
	input  logic [1:0]                          operation,
	input  logic [tmcr_pkg::CELL_W-1:0]         cell_col,
	input  logic [tmcr_pkg::CELL_W-1:0]         cell_row,
	input  logic                                cell_occupied,
	input  logic signed [tmcr_pkg::POS_W-1:0]   pos_x,
	input  logic signed [tmcr_pkg::POS_W-1:0]   pos_z,
	input  logic [tmcr_pkg::SIZE_W-1:0]         obj_size,
	input  logic signed [tmcr_pkg::POS_W-1:0]   move_x,
	input  logic signed [tmcr_pkg::POS_W-1:0]   move_z,
	input  logic                                out_ready,
	output logic                                out_valid,
	output logic                                hit,
	output logic                                out_of_bounds,
	output logic signed [tmcr_pkg::POS_W-1:0]   reflected_x,
	output logic signed [tmcr_pkg::POS_W-1:0]   reflected_z
);
	import tmcr_pkg::*;

	localparam int CW    = $clog2(MAX_COLS);
	localparam int RW    = $clog2(MAX_ROWS);
	localparam int AW    = CW + RW;
	localparam int DEPTH = 1 << AW;
	localparam int CTR_W = POS_W + 1;
	localparam int Q9_W  = 20;
	localparam int EDGE_W = 12;
	localparam int DIM_W = 9;

	localparam logic signed [Q9_W-1:0] HALF_Q9 = 20'sd256;
	localparam logic signed [Q9_W-1:0] DIV_ADJ = 20'sd511;
	localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};
	localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};

	// Division by 512 rounding toward zero.
	function automatic logic signed [EDGE_W-1:0] div512(input logic signed [Q9_W-1:0] q);
		logic signed [Q9_W-1:0] adj;
		adj = q + (q[Q9_W-1] ? DIV_ADJ : '0);
		return EDGE_W'(adj >>> 9);
	endfunction

	function automatic logic signed [POS_W-1:0] neg_sat(input logic signed [POS_W-1:0] v);
		return (v == POS_MIN) ? POS_MAX : -v;
	endfunction

	// Configuration.
	logic [CFG_W-1:0] map_w_q, map_h_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_w_q <= CFG_W'(64);
			map_h_q <= CFG_W'(64);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_MAP_WIDTH:  map_w_q <= cfg_data;
				CFG_MAP_HEIGHT: map_h_q <= cfg_data;
			endcase
		end
	end

	logic [DIM_W-1:0] eff_w, eff_h;
	assign eff_w = (DIM_W'(map_w_q) < DIM_W'(MAX_COLS)) ? DIM_W'(map_w_q) : DIM_W'(MAX_COLS);
	assign eff_h = (DIM_W'(map_h_q) < DIM_W'(MAX_ROWS)) ? DIM_W'(map_h_q) : DIM_W'(MAX_ROWS);

	logic signed [EDGE_W-1:0] w_s, h_s, half_w_s, half_h_s;
	assign w_s      = $signed({{(EDGE_W-DIM_W){1'b0}}, eff_w});
	assign h_s      = $signed({{(EDGE_W-DIM_W){1'b0}}, eff_h});
	assign half_w_s = $signed({{(EDGE_W-DIM_W+1){1'b0}}, eff_w[DIM_W-1:1]});
	assign half_h_s = $signed({{(EDGE_W-DIM_W+1){1'b0}}, eff_h[DIM_W-1:1]});

	// Captured item.
	logic [1:0]               op_q;
	logic [CELL_W-1:0]        col_w_q, row_w_q;
	logic                     occ_q;
	logic signed [POS_W-1:0]  px_q, pz_q, mx_q, mz_q;
	logic [SIZE_W-1:0]        size_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q    <= operation;
			col_w_q <= cell_col;
			row_w_q <= cell_row;
			occ_q   <= cell_occupied;
			px_q    <= pos_x;
			pz_q    <= pos_z;
			size_q  <= obj_size;
			mx_q    <= move_x;
			mz_q    <= move_z;
		end
	end

	// Window edges of the current test.
	logic                     is_reflect;
	logic signed [POS_W-1:0]  mx_sel, mz_sel;
	logic signed [CTR_W-1:0]  cx_q, cz_q;
	logic signed [Q9_W-1:0]   size_e, cx_e, cz_e;
	logic signed [Q9_W-1:0]   qxl_q, qxh_q, qzl_q, qzh_q;
	logic signed [EDGE_W-1:0] xlo_q, xhi_q, zlo_q, zhi_q;

	assign is_reflect = (op_q == OP_REFLECT);
	assign mx_sel = (is_reflect && !cmd.test_z) ? mx_q : '0;
	assign mz_sel = (is_reflect && cmd.test_z) ? mz_q : '0;
	assign size_e = $signed({{(Q9_W-SIZE_W){1'b0}}, size_q});
	assign cx_e   = Q9_W'(cx_q) <<< 1;
	assign cz_e   = Q9_W'(cz_q) <<< 1;

	always_ff @(posedge clk) begin
		if (cmd.center) begin
			cx_q <= CTR_W'(px_q) + CTR_W'(mx_sel);
			cz_q <= CTR_W'(pz_q) + CTR_W'(mz_sel);
		end
		if (cmd.edge_calc) begin
			qxl_q <= cx_e - size_e + HALF_Q9;
			qxh_q <= cx_e + size_e + HALF_Q9;
			qzl_q <= cz_e - size_e + HALF_Q9;
			qzh_q <= cz_e + size_e + HALF_Q9;
		end
		if (cmd.cell_calc) begin
			xlo_q <= div512(qxl_q) + half_w_s;
			xhi_q <= div512(qxh_q) + half_w_s;
			zlo_q <= div512(qzl_q) + half_h_s;
			zhi_q <= div512(qzh_q) + half_h_s;
		end
	end

	logic win_oob;
	assign win_oob = (xlo_q < 0) || (xhi_q >= w_s) || (zlo_q < 0) || (zhi_q >= h_s);

	// Scan counters and memory.
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [AW-1:0] clr_q;
	logic          scan_last, col_wrap;

	assign col_wrap  = (col_q == xhi_q[CW-1:0]);
	assign scan_last = col_wrap && (row_q == zhi_q[RW-1:0]);

	always_ff @(posedge clk) begin
		if (cmd.bound) begin
			col_q <= xlo_q[CW-1:0];
			row_q <= zlo_q[RW-1:0];
		end else if (cmd.scan) begin
			if (col_wrap) begin
				col_q <= xlo_q[CW-1:0];
				row_q <= row_q + RW'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) clr_q <= '0;
		else if (cmd.clear) clr_q <= clr_q + AW'(1);
	end

	logic [DIM_W-1:0] col_ext, row_ext;
	logic             write_ok, mem_we, mem_wdata;
	logic [AW-1:0]    mem_waddr, rd_addr;

	assign col_ext   = DIM_W'(col_w_q);
	assign row_ext   = DIM_W'(row_w_q);
	assign write_ok  = (col_ext < DIM_W'(MAX_COLS)) && (row_ext < DIM_W'(MAX_ROWS));
	assign mem_we    = cmd.clear || (cmd.write && write_ok);
	assign mem_waddr = cmd.clear ? clr_q : {row_ext[RW-1:0], col_ext[CW-1:0]};
	assign mem_wdata = cmd.clear ? 1'b0 : occ_q;
	assign rd_addr   = {row_q, col_q};

	logic grid_q [DEPTH];
	logic rd_s1;

	always_ff @(posedge clk) begin
		if (mem_we) grid_q[mem_waddr] <= mem_wdata;
		rd_s1 <= grid_q[rd_addr];
	end

	// Hit accumulation over a window.
	logic rd_vld_s1, acc_q, test_hit;
	logic hx_q, hz_q, oob_q;

	assign test_hit = acc_q | (rd_vld_s1 & rd_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) rd_vld_s1 <= 1'b0;
		else rd_vld_s1 <= cmd.scan;
	end

	always_ff @(posedge clk) begin
		if (cmd.bound) acc_q <= 1'b0;
		else if (rd_vld_s1) acc_q <= test_hit;

		if (cmd.load) begin
			hx_q  <= 1'b0;
			hz_q  <= 1'b0;
			oob_q <= 1'b0;
		end else begin
			if (cmd.bound) oob_q <= oob_q | win_oob;
			if (cmd.commit) begin
				if (cmd.test_z) hz_q <= test_hit;
				else hx_q <= test_hit;
			end
		end
	end

	// Output register.
	logic                    out_valid_q, hit_q, oob_out_q;
	logic signed [POS_W-1:0] rx_q, rz_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (cmd.finish) out_valid_q <= 1'b1;
		else if (out_ready) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			case (op_q)
				OP_CHECK: begin
					hit_q     <= hx_q;
					oob_out_q <= oob_q;
					rx_q      <= '0;
					rz_q      <= '0;
				end
				OP_REFLECT: begin
					hit_q     <= hx_q | hz_q;
					oob_out_q <= oob_q;
					rx_q      <= hx_q ? neg_sat(mx_q) : mx_q;
					rz_q      <= hz_q ? neg_sat(mz_q) : mz_q;
				end
				default: begin
					hit_q     <= 1'b0;
					oob_out_q <= 1'b0;
					rx_q      <= '0;
					rz_q      <= '0;
				end
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign hit           = hit_q;
	assign out_of_bounds = oob_out_q;
	assign reflected_x   = rx_q;
	assign reflected_z   = rz_q;

	assign status.clear_last = &clr_q;
	assign status.op         = op_q;
	assign status.win_oob    = win_oob;
	assign status.scan_last  = scan_last;
	assign status.out_busy   = out_valid_q & ~out_ready;

endmodule

[design/tile_map_collision_reflect.sv]
// ----------------------------------------------------------------------------
// tile_map_collision_reflect
// A check item tests one window; a reflect item tests the x-displaced and then the z-displaced
// one. The cells of an in-map window are read one per cycle; an out-of-map window reads none.
// The result goes valid as in_ready rises again. A result stalled at the output keeps the
// block in its finish state, so the next item waits until the result is taken.
// After reset the grid, all 2^(clog2(MAX_ROWS)+clog2(MAX_COLS)) cells (4096), is cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tile_map_collision_reflect #(
	parameter int MAX_COLS = 64,
	parameter int MAX_ROWS = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [tmcr_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [tmcr_pkg::CFG_W-1:0]          cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [1:0]                          operation,
	input  logic [tmcr_pkg::CELL_W-1:0]         cell_col,
	input  logic [tmcr_pkg::CELL_W-1:0]         cell_row,
	input  logic                                cell_occupied,
	input  logic signed [tmcr_pkg::POS_W-1:0]   pos_x,
	input  logic signed [tmcr_pkg::POS_W-1:0]   pos_z,
	input  logic [tmcr_pkg::SIZE_W-1:0]         obj_size,
	input  logic signed [tmcr_pkg::POS_W-1:0]   move_x,
	input  logic signed [tmcr_pkg::POS_W-1:0]   move_z,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                hit,
	output logic                                out_of_bounds,
	output logic signed [tmcr_pkg::POS_W-1:0]   reflected_x,
	output logic signed [tmcr_pkg::POS_W-1:0]   reflected_z
);
	import tmcr_pkg::*;

	cmd_t    cmd;
	status_t status;

	assign cfg_ready = 1'b1;

	tmcr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	tmcr_dp #(
		.MAX_COLS (MAX_COLS),
		.MAX_ROWS (MAX_ROWS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.cfg_valid     (cfg_valid),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.operation     (operation),
		.cell_col      (cell_col),
		.cell_row      (cell_row),
		.cell_occupied (cell_occupied),
		.pos_x         (pos_x),
		.pos_z         (pos_z),
		.obj_size      (obj_size),
		.move_x        (move_x),
		.move_z        (move_z),
		.out_ready     (out_ready),
		.out_valid     (out_valid),
		.hit           (hit),
		.out_of_bounds (out_of_bounds),
		.reflected_x   (reflected_x),
		.reflected_z   (reflected_z)
	);

endmodule

[design/tmcr_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmcr_checker
// Port-level checks on item flow through the tile map collision block.
// ----------------------------------------------------------------------------
module tmcr_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	input  logic                                in_ready,
	input  logic                                out_valid,
	input  logic                                out_ready,
	input  logic                                hit,
	input  logic                                out_of_bounds,
	input  logic signed [tmcr_pkg::POS_W-1:0]   reflected_x,
	input  logic signed [tmcr_pkg::POS_W-1:0]   reflected_z
);
	logic       in_acc, out_acc;
	logic [1:0] pending_q;

	assign in_acc  = in_valid & in_ready;
	assign out_acc = out_valid & out_ready;

	// Items accepted whose result has not been taken yet.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) pending_q <= '0;
		else pending_q <= pending_q + 2'(in_acc) - 2'(out_acc);
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(hit) && $stable(out_of_bounds)
			&& $stable(reflected_x) && $stable(reflected_z))
		else $error("result changed while stalled");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pending_q != 2'd0)
		else $error("result without an accepted item");

	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q != 2'd3)
		else $error("more than two items outstanding");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !in_ready)
		else $error("new item taken while previous one still at work");

endmodule

bind tile_map_collision_reflect tmcr_checker u_tmcr_checker (.*);

[test/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for tile_map_collision_reflect. An initial block queues
// directed and random items for a series of map sizes. A clocked driver feeds
// them with random gaps, and a clocked monitor stalls the result side at
// random. Each result is compared with a prediction made from the bench's own
// copy of the occupancy grid and map size.
// ----------------------------------------------------------------------------
module tb;
	import tmcr_pkg::*;

	localparam int MAP_COLS = 64;
	localparam int MAP_ROWS = 64;
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int ITEMS_PER_PHASE = 160;
	localparam int NUM_PHASES = 10;

	typedef struct packed {
		logic [1:0]               op;
		logic [CELL_W-1:0]        col;
		logic [CELL_W-1:0]        row;
		logic                     occ;
		logic signed [POS_W-1:0]  px;
		logic signed [POS_W-1:0]  pz;
		logic [SIZE_W-1:0]        side;
		logic signed [POS_W-1:0]  mx;
		logic signed [POS_W-1:0]  mz;
	} stim_t;

	typedef struct packed {
		logic                     hit;
		logic                     oob;
		logic signed [POS_W-1:0]  rx;
		logic signed [POS_W-1:0]  rz;
	} collision_t;

	logic                        clk;
	logic                        arst_n = 1'b0;
	logic                        cfg_valid = 1'b0;
	logic                        cfg_ready;
	logic [CFG_IDX_W-1:0]        cfg_index = '0;
	logic [CFG_W-1:0]            cfg_data = '0;
	logic                        in_valid = 1'b0;
	logic                        in_ready;
	logic [1:0]                  operation = OP_WRITE;
	logic [CELL_W-1:0]           cell_col = '0;
	logic [CELL_W-1:0]           cell_row = '0;
	logic                        cell_occupied = 1'b0;
	logic signed [POS_W-1:0]     pos_x = '0;
	logic signed [POS_W-1:0]     pos_z = '0;
	logic [SIZE_W-1:0]           obj_size = '0;
	logic signed [POS_W-1:0]     move_x = '0;
	logic signed [POS_W-1:0]     move_z = '0;
	logic                        out_valid;
	logic                        out_ready = 1'b0;
	logic                        hit;
	logic                        out_of_bounds;
	logic signed [POS_W-1:0]     reflected_x;
	logic signed [POS_W-1:0]     reflected_z;

	tile_map_collision_reflect dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.operation     (operation),
		.cell_col      (cell_col),
		.cell_row      (cell_row),
		.cell_occupied (cell_occupied),
		.pos_x         (pos_x),
		.pos_z         (pos_z),
		.obj_size      (obj_size),
		.move_x        (move_x),
		.move_z        (move_z),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.hit           (hit),
		.out_of_bounds (out_of_bounds),
		.reflected_x   (reflected_x),
		.reflected_z   (reflected_z)
	);

	// Bench copy of the block state.
	bit occ_grid [0:MAP_ROWS-1][0:MAP_COLS-1];
	int map_w = 64;
	int map_h = 64;

	stim_t      op_q [$];
	collision_t collision_q [$];
	int         outstanding = 0;
	int         mismatches = 0;

	stim_t      drv_cur;
	collision_t head;
	int in_gap = 0, in_calm = 0, out_gap = 0, out_calm = 0;

	int phase_w [NUM_PHASES] = '{64, 1, 0, 127, 1, 64, 2, 65, 33, 64};
	int phase_h [NUM_PHASES] = '{64, 1, 0, 127, 64, 1, 3, 40, 17, 64};

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Returns {out_of_bounds, hit} for one square window.
	function automatic logic [1:0] probe_window(int cx, int cz, int side);
		int w, h, left, right, top, bottom;
		w = (map_w < MAP_COLS) ? map_w : MAP_COLS;
		h = (map_h < MAP_ROWS) ? map_h : MAP_ROWS;
		left   = (2 * cx - side + 256) / 512 + w / 2;
		right  = (2 * cx + side + 256) / 512 + w / 2;
		top    = (2 * cz - side + 256) / 512 + h / 2;
		bottom = (2 * cz + side + 256) / 512 + h / 2;
		if (left < 0 || right >= w || top < 0 || bottom >= h)
			return 2'b10;
		for (int r = top; r <= bottom; r++)
			for (int c = left; c <= right; c++)
				if (occ_grid[r][c])
					return 2'b01;
		return 2'b00;
	endfunction

	function automatic logic signed [POS_W-1:0] negate_sat(int v);
		int n;
		n = -v;
		if (n > 32767)
			n = 32767;
		return n[POS_W-1:0];
	endfunction

	function automatic collision_t predict_collision(stim_t s);
		collision_t r;
		logic [1:0] ax, az;
		r = '0;
		case (s.op)
			OP_WRITE: begin
				occ_grid[s.row][s.col] = s.occ;
			end
			OP_CHECK: begin
				ax = probe_window(int'(s.px), int'(s.pz), int'(s.side));
				r.hit = ax[0];
				r.oob = ax[1];
			end
			OP_REFLECT: begin
				ax = probe_window(int'(s.px) + int'(s.mx), int'(s.pz), int'(s.side));
				az = probe_window(int'(s.px), int'(s.pz) + int'(s.mz), int'(s.side));
				r.hit = ax[0] | az[0];
				r.oob = ax[1] | az[1];
				r.rx = ax[0] ? negate_sat(int'(s.mx)) : s.mx;
				r.rz = az[0] ? negate_sat(int'(s.mz)) : s.mz;
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic stim_t mk(logic [1:0] op, int col, int row, int occ,
			int px, int pz, int side, int mx, int mz);
		stim_t s;
		s.op = op;
		s.col = col[CELL_W-1:0];
		s.row = row[CELL_W-1:0];
		s.occ = occ[0];
		s.px = px[POS_W-1:0];
		s.pz = pz[POS_W-1:0];
		s.side = side[SIZE_W-1:0];
		s.mx = mx[POS_W-1:0];
		s.mz = mz[POS_W-1:0];
		return s;
	endfunction

	// Centre coordinate within a couple of cells of the map.
	function automatic int rand_coord(int cells);
		int span;
		span = (cells / 2 + 2) * 256;
		return int'($urandom_range(0, 2 * span)) - span;
	endfunction

	function automatic int rand_move();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 70)
			return int'($urandom_range(0, 1024)) - 512;
		if (sel < 90)
			return int'($urandom_range(0, 8192)) - 4096;
		return $urandom;
	endfunction

	function automatic stim_t random_item();
		stim_t s;
		int w, h, kind, sel;
		w = (map_w < MAP_COLS) ? map_w : MAP_COLS;
		h = (map_h < MAP_ROWS) ? map_h : MAP_ROWS;
		s = mk($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom, $urandom);
		kind = $urandom_range(0, 99);
		// Noise: every field random, including the unused operation code.
		if (kind < 10)
			return s;
		if (kind < 42) begin
			s.op = OP_WRITE;
			if (w > 0 && $urandom_range(0, 4) != 0)
				s.col = CELL_W'($urandom_range(0, w - 1));
			if (h > 0 && $urandom_range(0, 4) != 0)
				s.row = CELL_W'($urandom_range(0, h - 1));
			s.occ = ($urandom_range(0, 3) == 0);
			return s;
		end
		s.op = (kind < 72) ? OP_CHECK : OP_REFLECT;
		s.px = POS_W'(rand_coord(w));
		s.pz = POS_W'(rand_coord(h));
		sel = $urandom_range(0, 99);
		if (sel < 80)
			s.side = SIZE_W'($urandom_range(0, 768));
		else if (sel < 98)
			s.side = SIZE_W'($urandom_range(0, 2560));
		else
			s.side = SIZE_W'($urandom_range(0, 16384));
		s.mx = POS_W'(rand_move());
		s.mz = POS_W'(rand_move());
		return s;
	endfunction

	task automatic queue_item(stim_t s);
		op_q.push_back(s);
		outstanding++;
	endtask

	task automatic settle();
		while (outstanding != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, int value);
		cfg_index <= idx;
		cfg_data <= value[CFG_W-1:0];
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == CFG_MAP_WIDTH)
			map_w = value & 127;
		else
			map_h = value & 127;
		@(posedge clk);
	endtask

	function automatic void check_field(string name, int want, int got);
		if (want != got) begin
			$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
			mismatches++;
		end
	endfunction

	// Driver: one item on the input channel, held until accepted.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready)
				collision_q.push_back(predict_collision(drv_cur));
			if (!(in_valid && !in_ready)) begin
				if (in_gap > 0) begin
					in_gap--;
					in_valid <= 1'b0;
				end else if (op_q.size() != 0) begin
					drv_cur = op_q.pop_front();
					operation <= drv_cur.op;
					cell_col <= drv_cur.col;
					cell_row <= drv_cur.row;
					cell_occupied <= drv_cur.occ;
					pos_x <= drv_cur.px;
					pos_z <= drv_cur.pz;
					obj_size <= drv_cur.side;
					move_x <= drv_cur.mx;
					move_z <= drv_cur.mz;
					in_valid <= 1'b1;
					if (in_calm > 0) begin
						in_calm--;
					end else begin
						in_gap = idle_len();
						if ($urandom_range(0, 39) == 0)
							in_calm = $urandom_range(20, 80);
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: compares each accepted result with the oldest prediction.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (collision_q.size() == 0) begin
					$display("%0t: unexpected result hit %0b oob %0b x %0d z %0d",
						$time, hit, out_of_bounds, reflected_x, reflected_z);
					mismatches++;
				end else begin
					head = collision_q.pop_front();
					check_field("hit", head.hit, hit);
					check_field("out_of_bounds", head.oob, out_of_bounds);
					check_field("reflected_x", head.rx, reflected_x);
					check_field("reflected_z", head.rz, reflected_z);
					outstanding--;
				end
			end
			if (out_gap > 0) begin
				out_gap--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				if (out_calm > 0) begin
					out_calm--;
				end else if ($urandom_range(0, 3) == 0) begin
					out_gap = idle_len();
					if ($urandom_range(0, 39) == 0)
						out_calm = $urandom_range(20, 200);
				end
			end
		end
	end

	initial begin : stimulus
		int w_sel, h_sel;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// Directed items on the reset map of 64 by 64, centre cell (32, 32).
		queue_item(mk(OP_WRITE, 32, 32, 1, 0, 0, 0, 0, 0));
		queue_item(mk(OP_WRITE, 0, 0, 1, 0, 0, 0, 0, 0));
		queue_item(mk(OP_WRITE, 63, 63, 1, 0, 0, 0, 0, 0));
		queue_item(mk(OP_WRITE, 63, 0, 0, 0, 0, 0, 0, 0));
		queue_item(mk(OP_WRITE, 0, 63, 1, -1, -1, 32767, -1, -1));
		queue_item(mk(OP_CHECK, 0, 0, 0, 0, 0, 0, 0, 0));
		queue_item(mk(OP_CHECK, 0, 0, 0, 0, 0, 32767, 0, 0));
		queue_item(mk(OP_CHECK, 0, 0, 0, -32768, -32768, 0, 0, 0));
		queue_item(mk(OP_CHECK, 63, 63, 1, 32767, 32767, 0, 0, 0));
		queue_item(mk(OP_CHECK, 0, 0, 0, -8320, -8320, 0, 0, 0));
		queue_item(mk(OP_CHECK, 0, 0, 0, -8576, -8320, 0, 0, 0));
		queue_item(mk(OP_CHECK, 0, 0, 0, 8063, 8063, 0, 0, 0));
		queue_item(mk(OP_CHECK, 0, 0, 0, 8063, 8064, 0, 0, 0));
		queue_item(mk(OP_CHECK, 0, 0, 0, 0, 0, 768, 0, 0));
		// Reflect that must negate -32768 on each axis in turn.
		queue_item(mk(OP_REFLECT, 0, 0, 0, 32767, 0, 0, -32768, 0));
		queue_item(mk(OP_REFLECT, 0, 0, 0, 0, 32767, 0, 0, -32768));
		queue_item(mk(OP_REFLECT, 0, 0, 0, 0, 0, 0, 32767, 5));
		queue_item(mk(OP_REFLECT, 0, 0, 0, 0, 0, 0, 10, -10));
		queue_item(mk(OP_REFLECT, 0, 0, 0, -2560, 2560, 256, 300, -300));
		queue_item(mk(OP_UNUSED, 63, 63, 1, -1, -1, 32767, -1, -1));
		queue_item(mk(OP_WRITE, 32, 32, 0, 0, 0, 0, 0, 0));
		queue_item(mk(OP_CHECK, 0, 0, 0, 0, 0, 0, 0, 0));
		settle();

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			w_sel = phase_w[ph];
			h_sel = phase_h[ph];
			if (ph == NUM_PHASES - 1) begin
				w_sel = $urandom_range(0, 127);
				h_sel = $urandom_range(0, 127);
			end
			cfg_write(CFG_MAP_WIDTH, w_sel);
			cfg_write(CFG_MAP_HEIGHT, h_sel);
			repeat (ITEMS_PER_PHASE) queue_item(random_item());
			settle();
		end

		repeat (50) @(posedge clk);
		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin : watchdog
		#20_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

[filelist.f]
design/tmcr_pkg.sv
design/tmcr_ctrl.sv
design/tmcr_dp.sv
design/tile_map_collision_reflect.sv
design/tmcr_checker.sv
test/tb.sv
